>>> hdl/batd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batd_pkg
// shared constants, codes and handshake structs of the thumbnail downscaler
// ----------------------------------------------------------------------------
package batd_pkg;

    localparam int DEF_MAX_THUMB_WIDTH = 256;
    localparam int DEF_MAX_SCREEN_DIM  = 2048;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int PIX_W      = 32;
    localparam int SUM_W      = 30;
    localparam int NUM_CH     = 4;
    localparam int DIV_W      = 32;
    localparam int RECIP_W    = 17;
    localparam int FRAC_SHIFT = 16;

    localparam logic [11:0] RST_SCREEN_W = 12'd800;
    localparam logic [11:0] RST_SCREEN_H = 12'd600;
    localparam logic [8:0]  RST_THUMB_W  = 9'd132;
    localparam logic [8:0]  RST_THUMB_H  = 9'd100;
    localparam logic [3:0]  RST_REDUCE   = 4'd6;

    localparam logic [31:0] FRAC_ONE = 32'd65536;
    localparam logic [31:0] BYTE_MAX = 32'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_THUMB_WIDTH   = 3'd2,
        REG_THUMB_HEIGHT  = 3'd3,
        REG_REDUCE_FACTOR = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

>>> hdl/batd_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batd_pix_if
// screen pixel channel: valid, ready and one pixel request
// ----------------------------------------------------------------------------
interface batd_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel;
    logic        frame_start;

    modport source (output valid, pixel, frame_start, input ready);
    modport sink   (input valid, pixel, frame_start, output ready);
endinterface

>>> hdl/batd_thumb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batd_thumb_if
// thumbnail pixel channel: valid, ready and one averaged pixel request
// ----------------------------------------------------------------------------
interface batd_thumb_if;
    logic        valid;
    logic        ready;
    logic [31:0] thumb_pixel;
    logic        thumb_last;

    modport source (output valid, thumb_pixel, thumb_last, input ready);
    modport sink   (input valid, thumb_pixel, thumb_last, output ready);
endinterface

>>> hdl/batd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module batd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

>>> hdl/batd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batd_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module batd_div (
    input  logic               clk,
    input  logic               rst_n,
    input  batd_pkg::div_req_t req,
    output batd_pkg::div_rsp_t rsp
);
    import batd_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W:0]   rem_diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rem_shift = {rem_reg, num_reg[DIV_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // trial subtract, keep the shifted remainder on a borrow
            if (!rem_diff[DIV_W])
            begin
                rem_next = rem_diff[DIV_W-1:0];
                num_next = {num_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DIV_W-1:0];
                num_next = {num_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;
    assign rsp.rem  = rem_reg;
endmodule

>>> hdl/box_average_thumbnail_downscaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_thumbnail_downscaler
// box filter downscaler: raster screen pixels in, averaged thumbnail pixels out
//
//   channel   dir  handshake      payload
//   pixels    in   valid/ready    pixel[31:0], frame_start
//   thumbs    out  valid/ready    thumb_pixel[31:0], thumb_last
//   cfg       in   cfg_wr_en      cfg_index[2:0], cfg_data[11:0]
//
// a pixel request outside every cell is taken in S_IDLE alone; one inside a
// cell reads the column sums from the ram in S_IDLE, then adds and writes
// back in S_ACC, so a read never sees an entry still in flight
// a pixel that closes a cell then runs, in fit mode, a multiply and clamp per
// byte, then the push, or otherwise the serial divider, one byte after
// another, then the push; the push waits while the output register is still full
// after reset a clearing pass zeroes the sums, then the geometry is derived;
// every register write redoes the derivation on the shared divider, with
// pixels held off meanwhile
// a finished thumbnail pixel waits in the output register while pixels go on
// ----------------------------------------------------------------------------
module box_average_thumbnail_downscaler #(
    parameter int MAX_THUMB_WIDTH = batd_pkg::DEF_MAX_THUMB_WIDTH,
    parameter int MAX_SCREEN_DIM  = batd_pkg::DEF_MAX_SCREEN_DIM
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [batd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [batd_pkg::CFG_DATA_W-1:0] cfg_data,
    batd_pix_if.sink                       pixels,
    batd_thumb_if.source                   thumbs
);
    import batd_pkg::*;

    // position width leaves room for fit cells that run past the screen
    localparam int PW    = $clog2(MAX_SCREEN_DIM) + 5;
    localparam int TCW   = $clog2(MAX_THUMB_WIDTH) + 1;
    localparam int MAW   = $clog2(MAX_THUMB_WIDTH);
    localparam int WORDW = NUM_CH * SUM_W;
    localparam int PRODW = SUM_W + RECIP_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CFG, S_CFG_WAIT, S_CFG_FIN,
        S_ACC, S_MUL, S_SAT, S_NDIV, S_NWAIT, S_PUSH
    } state_t;

    // order of the divisions run after reset and after a register write
    typedef enum logic [2:0] {
        K_WR, K_HR, K_WX, K_HY, K_CX, K_CY, K_RC
    } cfg_step_t;

    // raw registers
    logic [11:0] sw_reg, sw_next;
    logic [11:0] sh_reg, sh_next;
    logic [8:0]  tw_reg, tw_next;
    logic [8:0]  th_reg, th_next;
    logic [3:0]  rf_reg, rf_next;
    logic        dirty_reg, dirty_next;

    state_t      state_reg, state_next;
    cfg_step_t   k_reg, k_next;
    logic [MAW-1:0] clr_reg, clr_next;
    logic [1:0]  ch_reg, ch_next;

    // divider results kept during the derive sequence
    logic              fw_reg, fw_next;
    logic              fh_reg, fh_next;
    logic [PW-1:0]     xqn_reg, xqn_next, xrn_reg, xrn_next;
    logic [PW-1:0]     yqn_reg, yqn_next, yrn_reg, yrn_next;
    logic [PW-1:0]     csn_reg, csn_next, cremn_reg, cremn_next;
    logic [PW-1:0]     rsn_reg, rsn_next, rremn_reg, rremn_next;

    // derived geometry
    logic              fit_reg, fit_next;
    logic [PW-1:0]     xq_reg, xq_next, xr_reg, xr_next, x0_reg, x0_next;
    logic [PW-1:0]     yq_reg, yq_next, yr_reg, yr_next, y0_reg, y0_next;
    logic [DIV_W-1:0]  dv_reg, dv_next;
    logic [RECIP_W-1:0] recip_reg, recip_next;

    // scan position
    logic [PW-1:0]     col_reg, col_next, row_reg, row_next;
    logic [TCW-1:0]    cc_reg, cc_next;
    logic [PW-1:0]     cr_reg, cr_next;
    logic [PW-1:0]     cs_reg, cs_next, crem_reg, crem_next;
    logic [PW-1:0]     rs_reg, rs_next, rrem_reg, rrem_next;

    // request in flight
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic              first_reg, first_next;
    logic              emit_reg, emit_next;
    logic              tlast_reg, tlast_next;
    logic [MAW-1:0]    addr_reg, addr_next;
    logic [SUM_W-1:0]  sums_reg [NUM_CH];
    logic [SUM_W-1:0]  sums_next [NUM_CH];
    logic [PRODW-1:0]  prod_reg, prod_next;
    logic [7:0]        byte_reg [NUM_CH];
    logic [7:0]        byte_next [NUM_CH];

    // output register
    logic              oval_reg, oval_next;
    logic [PIX_W-1:0]  opix_reg, opix_next;
    logic              olast_reg, olast_next;

    // clamped geometry
    logic [31:0] w32, h32, tlim32, tw32, th32, r32;
    logic [PW-1:0]  w_g, h_g, th_g;
    logic [TCW-1:0] tw_g;
    logic           special;

    div_req_t dreq;
    div_rsp_t drsp;

    logic             ram_we, ram_re;
    logic [MAW-1:0]   ram_waddr, ram_raddr;
    logic [WORDW-1:0] ram_wdata, ram_rdata, acc_word;

    // effective scan values after a frame start
    logic           accept;
    logic [PW-1:0]  c_e, r_e, cr_e, cs_e, crem_e, rs_e, rrem_e;
    logic [TCW-1:0] cc_e;
    logic           hit, lastc, lastr;
    logic [PW-1:0]  xsum, ysum;
    logic [31:0]    rtw, rth, offx, offy;
    logic [PRODW-FRAC_SHIFT-1:0] prod_hi;

    always_comb
    begin
        w32    = (sw_reg == 12'd0) ? 32'd1 :
                 (32'(sw_reg) > 32'(MAX_SCREEN_DIM)) ? 32'(MAX_SCREEN_DIM) : 32'(sw_reg);
        h32    = (sh_reg == 12'd0) ? 32'd1 :
                 (32'(sh_reg) > 32'(MAX_SCREEN_DIM)) ? 32'(MAX_SCREEN_DIM) : 32'(sh_reg);
        tlim32 = (w32 < 32'(MAX_THUMB_WIDTH)) ? w32 : 32'(MAX_THUMB_WIDTH);
        tw32   = (tw_reg == 9'd0) ? 32'd1 : (32'(tw_reg) > tlim32) ? tlim32 : 32'(tw_reg);
        th32   = (th_reg == 9'd0) ? 32'd1 : (32'(th_reg) > h32) ? h32 : 32'(th_reg);
        r32    = (rf_reg == 4'd0) ? 32'd1 : 32'(rf_reg);
        w_g    = PW'(w32);
        h_g    = PW'(h32);
        tw_g   = TCW'(tw32);
        th_g   = PW'(th32);
        // the stock 800x600 screen into a 132x100 thumbnail with reduce 6
        special = (rf_reg == RST_REDUCE) && (w32 == 32'(RST_SCREEN_W)) &&
                  (h32 == 32'(RST_SCREEN_H)) && (tw32 == 32'(RST_THUMB_W)) &&
                  (th32 == 32'(RST_THUMB_H));
        rtw  = r32 * tw32;
        rth  = r32 * th32;
        offx = (w32 >= rtw) ? ((w32 - rtw) >> 1) : 32'd0;
        offy = (h32 >= rth) ? ((h32 - rth) >> 1) : 32'd0;
    end

    // membership of the current pixel in the current cell
    always_comb
    begin
        accept = pixels.valid && pixels.ready;
        c_e    = pixels.frame_start ? '0 : col_reg;
        r_e    = pixels.frame_start ? '0 : row_reg;
        cc_e   = pixels.frame_start ? '0 : cc_reg;
        cr_e   = pixels.frame_start ? '0 : cr_reg;
        cs_e   = pixels.frame_start ? x0_reg : cs_reg;
        crem_e = pixels.frame_start ? '0 : crem_reg;
        rs_e   = pixels.frame_start ? y0_reg : rs_reg;
        rrem_e = pixels.frame_start ? '0 : rrem_reg;
        lastc  = (c_e == cs_e + xq_reg - PW'(1));
        lastr  = (r_e == rs_e + yq_reg - PW'(1));
        hit    = (cr_e < th_g) && (r_e >= rs_e) && (r_e < rs_e + yq_reg) &&
                 (cc_e < tw_g) && (c_e >= cs_e) && (c_e < cs_e + xq_reg);
        // remainders stay below the cell count, so one subtract wraps them
        xsum   = crem_e + xr_reg;
        ysum   = rrem_e + yr_reg;
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            acc_word[k*SUM_W +: SUM_W] = first_reg ? SUM_W'(pix_reg[8*k +: 8]) :
                ram_rdata[k*SUM_W +: SUM_W] + SUM_W'(pix_reg[8*k +: 8]);
        end
        prod_hi = prod_reg[PRODW-1:FRAC_SHIFT];
    end

    // divider is shared by the geometry sequence and the exact averages
    always_comb
    begin
        dreq.start = (state_reg == S_CFG) || (state_reg == S_NDIV);
        dreq.num   = 32'(sums_reg[ch_reg]);
        dreq.den   = dv_reg;
        if (state_reg == S_CFG)
        begin
            case (k_reg)
                K_WR:
                begin
                    dreq.num = w32;
                    dreq.den = r32;
                end
                K_HR:
                begin
                    dreq.num = h32;
                    dreq.den = r32;
                end
                K_WX:
                begin
                    dreq.num = w32;
                    dreq.den = tw32;
                end
                K_HY:
                begin
                    dreq.num = h32;
                    dreq.den = th32;
                end
                K_CX:
                begin
                    dreq.num = w32 * 32'(cc_reg);
                    dreq.den = tw32;
                end
                K_CY:
                begin
                    dreq.num = h32 * 32'(cr_reg);
                    dreq.den = th32;
                end
                K_RC:
                begin
                    dreq.num = FRAC_ONE;
                    dreq.den = r32 * r32;
                end
                default:
                begin
                    dreq.num = w32;
                    dreq.den = r32;
                end
            endcase
        end
    end

    always_comb
    begin
        sw_next    = sw_reg;
        sh_next    = sh_reg;
        tw_next    = tw_reg;
        th_next    = th_reg;
        rf_next    = rf_reg;
        dirty_next = dirty_reg;
        state_next = state_reg;
        k_next     = k_reg;
        clr_next   = clr_reg;
        ch_next    = ch_reg;
        fw_next    = fw_reg;
        fh_next    = fh_reg;
        xqn_next   = xqn_reg;
        xrn_next   = xrn_reg;
        yqn_next   = yqn_reg;
        yrn_next   = yrn_reg;
        csn_next   = csn_reg;
        cremn_next = cremn_reg;
        rsn_next   = rsn_reg;
        rremn_next = rremn_reg;
        fit_next   = fit_reg;
        xq_next    = xq_reg;
        xr_next    = xr_reg;
        x0_next    = x0_reg;
        yq_next    = yq_reg;
        yr_next    = yr_reg;
        y0_next    = y0_reg;
        dv_next    = dv_reg;
        recip_next = recip_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cc_next    = cc_reg;
        cr_next    = cr_reg;
        cs_next    = cs_reg;
        crem_next  = crem_reg;
        rs_next    = rs_reg;
        rrem_next  = rrem_reg;
        pix_next   = pix_reg;
        first_next = first_reg;
        emit_next  = emit_reg;
        tlast_next = tlast_reg;
        addr_next  = addr_reg;
        sums_next  = sums_reg;
        prod_next  = prod_reg;
        byte_next  = byte_reg;
        oval_next  = oval_reg;
        opix_next  = opix_reg;
        olast_next = olast_reg;

        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = acc_word;
        ram_re    = 1'b0;
        ram_raddr = cc_e[MAW-1:0];

        if (oval_reg && thumbs.ready)
        begin
            oval_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + MAW'(1);
                if (clr_reg == MAW'(MAX_THUMB_WIDTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (dirty_reg)
                begin
                    dirty_next = 1'b0;
                    k_next     = K_WR;
                    state_next = S_CFG;
                end
                else if (accept)
                begin
                    ram_re     = 1'b1;
                    pix_next   = pixels.pixel;
                    first_next = (r_e == rs_e) && (c_e == cs_e);
                    emit_next  = lastc && lastr;
                    tlast_next = (cc_e == tw_g - TCW'(1)) && (cr_e == th_g - PW'(1));
                    addr_next  = cc_e[MAW-1:0];
                    if (hit)
                    begin
                        state_next = S_ACC;
                    end
                    // scan counters
                    col_next  = c_e + PW'(1);
                    cc_next   = cc_e;
                    cs_next   = cs_e;
                    crem_next = crem_e;
                    cr_next   = cr_e;
                    rs_next   = rs_e;
                    rrem_next = rrem_e;
                    row_next  = r_e;
                    if (hit && lastc)
                    begin
                        cc_next = cc_e + TCW'(1);
                        if (xsum >= PW'(tw_g))
                        begin
                            cs_next   = cs_e + xq_reg + PW'(1);
                            crem_next = xsum - PW'(tw_g);
                        end
                        else
                        begin
                            cs_next   = cs_e + xq_reg;
                            crem_next = xsum;
                        end
                    end
                    // end of a screen row
                    if (c_e + PW'(1) >= w_g)
                    begin
                        col_next  = '0;
                        cc_next   = '0;
                        cs_next   = x0_reg;
                        crem_next = '0;
                        if ((cr_e < th_g) && (r_e + PW'(1) >= rs_e + yq_reg))
                        begin
                            cr_next = cr_e + PW'(1);
                            if (ysum >= th_g)
                            begin
                                rs_next   = rs_e + yq_reg + PW'(1);
                                rrem_next = ysum - th_g;
                            end
                            else
                            begin
                                rs_next   = rs_e + yq_reg;
                                rrem_next = ysum;
                            end
                        end
                        if (r_e + PW'(1) >= h_g)
                        begin
                            row_next  = '0;
                            cr_next   = '0;
                            rs_next   = y0_reg;
                            rrem_next = '0;
                        end
                        else
                        begin
                            row_next = r_e + PW'(1);
                        end
                    end
                end
            end
            S_CFG:
            begin
                state_next = S_CFG_WAIT;
            end
            S_CFG_WAIT:
            begin
                if (drsp.done)
                begin
                    state_next = S_CFG;
                    case (k_reg)
                        K_WR:
                        begin
                            fw_next = (drsp.quot == tw32);
                            k_next  = K_HR;
                        end
                        K_HR:
                        begin
                            fh_next = (drsp.quot == th32);
                            k_next  = K_WX;
                        end
                        K_WX:
                        begin
                            xqn_next = PW'(drsp.quot);
                            xrn_next = PW'(drsp.rem);
                            k_next   = K_HY;
                        end
                        K_HY:
                        begin
                            yqn_next = PW'(drsp.quot);
                            yrn_next = PW'(drsp.rem);
                            k_next   = K_CX;
                        end
                        K_CX:
                        begin
                            csn_next   = PW'(drsp.quot);
                            cremn_next = PW'(drsp.rem);
                            k_next     = K_CY;
                        end
                        K_CY:
                        begin
                            rsn_next   = PW'(drsp.quot);
                            rremn_next = PW'(drsp.rem);
                            k_next     = K_RC;
                        end
                        K_RC:
                        begin
                            recip_next = RECIP_W'(drsp.quot);
                            state_next = S_CFG_FIN;
                        end
                        default:
                        begin
                            state_next = S_CFG_FIN;
                        end
                    endcase
                end
            end
            S_CFG_FIN:
            begin
                state_next = S_IDLE;
                fit_next   = (fw_reg && fh_reg) || special;
                dv_next    = 32'(xqn_reg) * 32'(yqn_reg);
                if ((fw_reg && fh_reg) || special)
                begin
                    // fit cells are evenly spaced from a centered offset
                    xq_next   = PW'(r32);
                    xr_next   = '0;
                    x0_next   = PW'(offx);
                    yq_next   = PW'(r32);
                    yr_next   = '0;
                    y0_next   = PW'(offy);
                    cs_next   = PW'(offx + r32 * 32'(cc_reg));
                    crem_next = '0;
                    rs_next   = PW'(offy + r32 * 32'(cr_reg));
                    rrem_next = '0;
                end
                else
                begin
                    xq_next   = xqn_reg;
                    xr_next   = xrn_reg;
                    x0_next   = '0;
                    yq_next   = yqn_reg;
                    yr_next   = yrn_reg;
                    y0_next   = '0;
                    cs_next   = csn_reg;
                    crem_next = cremn_reg;
                    rs_next   = rsn_reg;
                    rrem_next = rremn_reg;
                end
            end
            S_ACC:
            begin
                ram_we     = 1'b1;
                state_next = S_IDLE;
                if (emit_reg)
                begin
                    for (int k = 0; k < NUM_CH; k++)
                    begin
                        sums_next[k] = acc_word[k*SUM_W +: SUM_W];
                    end
                    ch_next    = '0;
                    state_next = fit_reg ? S_MUL : S_NDIV;
                end
            end
            S_MUL:
            begin
                prod_next  = PRODW'(sums_reg[ch_reg]) * PRODW'(recip_reg);
                state_next = S_SAT;
            end
            S_SAT:
            begin
                byte_next[ch_reg] = (32'(prod_hi) > BYTE_MAX) ? 8'hff : prod_hi[7:0];
                ch_next           = ch_reg + 2'd1;
                state_next        = (ch_reg == 2'(NUM_CH - 1)) ? S_PUSH : S_MUL;
            end
            S_NDIV:
            begin
                state_next = S_NWAIT;
            end
            S_NWAIT:
            begin
                if (drsp.done)
                begin
                    byte_next[ch_reg] = (drsp.quot > BYTE_MAX) ? 8'hff : drsp.quot[7:0];
                    ch_next           = ch_reg + 2'd1;
                    if (ch_reg == 2'(NUM_CH - 2))
                    begin
                        // alpha is dropped outside fit mode
                        byte_next[NUM_CH-1] = 8'h00;
                        state_next          = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_NDIV;
                    end
                end
            end
            S_PUSH:
            begin
                if (!oval_reg || thumbs.ready)
                begin
                    oval_next  = 1'b1;
                    opix_next  = {byte_reg[3], byte_reg[2], byte_reg[1], byte_reg[0]};
                    olast_next = tlast_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register writes, taken in any state
        if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SCREEN_WIDTH:
                begin
                    sw_next    = cfg_data[11:0];
                    dirty_next = 1'b1;
                end
                REG_SCREEN_HEIGHT:
                begin
                    sh_next    = cfg_data[11:0];
                    dirty_next = 1'b1;
                end
                REG_THUMB_WIDTH:
                begin
                    tw_next    = cfg_data[8:0];
                    dirty_next = 1'b1;
                end
                REG_THUMB_HEIGHT:
                begin
                    th_next    = cfg_data[8:0];
                    dirty_next = 1'b1;
                end
                REG_REDUCE_FACTOR:
                begin
                    rf_next    = cfg_data[3:0];
                    dirty_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg    <= RST_SCREEN_W;
            sh_reg    <= RST_SCREEN_H;
            tw_reg    <= RST_THUMB_W;
            th_reg    <= RST_THUMB_H;
            rf_reg    <= RST_REDUCE;
            dirty_reg <= 1'b1;
            state_reg <= S_CLEAR;
            k_reg     <= K_WR;
            clr_reg   <= '0;
            ch_reg    <= '0;
            fw_reg    <= 1'b0;
            fh_reg    <= 1'b0;
            xqn_reg   <= '0;
            xrn_reg   <= '0;
            yqn_reg   <= '0;
            yrn_reg   <= '0;
            csn_reg   <= '0;
            cremn_reg <= '0;
            rsn_reg   <= '0;
            rremn_reg <= '0;
            fit_reg   <= 1'b1;
            xq_reg    <= '0;
            xr_reg    <= '0;
            x0_reg    <= '0;
            yq_reg    <= '0;
            yr_reg    <= '0;
            y0_reg    <= '0;
            dv_reg    <= '0;
            recip_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            cc_reg    <= '0;
            cr_reg    <= '0;
            cs_reg    <= '0;
            crem_reg  <= '0;
            rs_reg    <= '0;
            rrem_reg  <= '0;
            pix_reg   <= '0;
            first_reg <= 1'b0;
            emit_reg  <= 1'b0;
            tlast_reg <= 1'b0;
            addr_reg  <= '0;
            sums_reg  <= '{default: '0};
            prod_reg  <= '0;
            byte_reg  <= '{default: '0};
            oval_reg  <= 1'b0;
            opix_reg  <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            sw_reg    <= sw_next;
            sh_reg    <= sh_next;
            tw_reg    <= tw_next;
            th_reg    <= th_next;
            rf_reg    <= rf_next;
            dirty_reg <= dirty_next;
            state_reg <= state_next;
            k_reg     <= k_next;
            clr_reg   <= clr_next;
            ch_reg    <= ch_next;
            fw_reg    <= fw_next;
            fh_reg    <= fh_next;
            xqn_reg   <= xqn_next;
            xrn_reg   <= xrn_next;
            yqn_reg   <= yqn_next;
            yrn_reg   <= yrn_next;
            csn_reg   <= csn_next;
            cremn_reg <= cremn_next;
            rsn_reg   <= rsn_next;
            rremn_reg <= rremn_next;
            fit_reg   <= fit_next;
            xq_reg    <= xq_next;
            xr_reg    <= xr_next;
            x0_reg    <= x0_next;
            yq_reg    <= yq_next;
            yr_reg    <= yr_next;
            y0_reg    <= y0_next;
            dv_reg    <= dv_next;
            recip_reg <= recip_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cc_reg    <= cc_next;
            cr_reg    <= cr_next;
            cs_reg    <= cs_next;
            crem_reg  <= crem_next;
            rs_reg    <= rs_next;
            rrem_reg  <= rrem_next;
            pix_reg   <= pix_next;
            first_reg <= first_next;
            emit_reg  <= emit_next;
            tlast_reg <= tlast_next;
            addr_reg  <= addr_next;
            sums_reg  <= sums_next;
            prod_reg  <= prod_next;
            byte_reg  <= byte_next;
            oval_reg  <= oval_next;
            opix_reg  <= opix_next;
            olast_reg <= olast_next;
        end
    end

    // per thumbnail column, four byte sums side by side
    batd_ram #(
        .WIDTH (WORDW),
        .DEPTH (MAX_THUMB_WIDTH)
    ) u_sums (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    batd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign pixels.ready       = (state_reg == S_IDLE) && !dirty_reg;
    assign thumbs.valid       = oval_reg;
    assign thumbs.thumb_pixel = opix_reg;
    assign thumbs.thumb_last  = olast_reg;
endmodule
